FILE: rtl/core/vcu_pkg.sv
// Package for the vector clock unit: field widths, item kinds, relation codes, register indexes.
package vcu_pkg;

    // Field widths fixed by the item format
    localparam int KIND_W      = 2;
    localparam int SLOT_W      = 4;
    localparam int VALUE_W     = 32;
    localparam int SIZE_W      = 5;
    localparam int REL_W       = 2;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 5;

    // Reset value of the clock size register
    localparam logic [SIZE_W-1:0] CLOCK_SIZE_RST = 5'd16;

    // Compare position saturates here
    localparam logic [SIZE_W-1:0] POS_MAX = 5'd31;

    // Item and result kinds (code 3 means nothing and is dropped)
    typedef enum logic [KIND_W-1:0] {
        KIND_TICK = 2'd0,
        KIND_RECV = 2'd1,
        KIND_CMP  = 2'd2
    } t_kind;

    // Relation of the local clock to the compared clock
    typedef enum logic [REL_W-1:0] {
        REL_EQUAL  = 2'd0,
        REL_BEFORE = 2'd1,
        REL_AFTER  = 2'd2,
        REL_CONC   = 2'd3
    } t_rel;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_OWNER_INDEX = 2'd0,
        CFG_CLOCK_SIZE  = 2'd1
    } t_cfg_reg;

endpackage

FILE: rtl/core/vcu_if.sv
// Channel interfaces of the vector clock unit: item input, result output, register writes.
interface vcu_in_if;
    import vcu_pkg::*;

    logic               valid;
    logic               ready;
    logic [KIND_W-1:0]  kind;
    logic [SLOT_W-1:0]  sender_index;
    logic [VALUE_W-1:0] sender_value;
    logic [SIZE_W-1:0]  sender_size;
    logic [VALUE_W-1:0] compare_value;
    logic               compare_last;

    modport source (
        output valid, kind, sender_index, sender_value, sender_size,
               compare_value, compare_last,
        input  ready
    );
    modport sink (
        input  valid, kind, sender_index, sender_value, sender_size,
               compare_value, compare_last,
        output ready
    );
endinterface

interface vcu_out_if;
    import vcu_pkg::*;

    logic               valid;
    logic               ready;
    logic [KIND_W-1:0]  result_kind;
    logic [VALUE_W-1:0] own_count;
    logic [REL_W-1:0]   relation;
    logic               size_mismatch;

    modport source (
        output valid, result_kind, own_count, relation, size_mismatch,
        input  ready
    );
    modport sink (
        input  valid, result_kind, own_count, relation, size_mismatch,
        output ready
    );
endinterface

interface vcu_cfg_if;
    import vcu_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (
        output valid, index, data,
        input  ready
    );
    modport sink (
        input  valid, index, data,
        output ready
    );
endinterface

FILE: rtl/core/vector_clock_unit.sv
// Vector clock unit: event counters per process slot, tick, receive and streamed compare.
//
// Channels: i_in takes one item word per handshake (tick, receive or compare
// element); o_out gives at most one result word per item; i_cfg writes the
// owner slot (index 0) and the clock size (index 1), and is always ready.
// The user must write configuration only while no item is in flight; the
// block itself does not enforce it. Each accepted word lands in an input
// register; from there a single pass of logic reads one counter (the owner's,
// or the compare position's), updates the counters and compare flags and loads
// the result register. A result passes the input register and then the result
// register before o_out.valid rises. Throughput is one item per cycle while
// o_out is not stalled, set by the single counter read per pass.
// Non-last compare elements and kind 3 give no result.
// A stalled o_out holds the result register; the input register then holds
// one more word and i_in.ready drops until the result is taken.
// Reset (synchronous, active low) clears all counters, the compare state,
// both valid flags, the owner slot to 0 and the clock size to 16.
module vector_clock_unit #(
    parameter int MAX_ENTRIES = 16,
    parameter int COUNT_BITS  = 32
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    vcu_in_if.sink    i_in,
    vcu_out_if.source o_out,
    vcu_cfg_if.sink   i_cfg
);
    import vcu_pkg::*;

    localparam int IW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CW = (COUNT_BITS > VALUE_W) ? COUNT_BITS : VALUE_W;

    // Configuration registers
    logic [SLOT_W-1:0] r_owner;
    logic [SIZE_W-1:0] r_clock_size;

    // Counter storage and compare state
    logic [COUNT_BITS-1:0] r_counters [MAX_ENTRIES];
    logic [SIZE_W-1:0]     r_cmp_pos;
    logic                  r_seen_smaller;
    logic                  r_seen_larger;

    // Input register
    logic               r_in_valid;
    logic [KIND_W-1:0]  r_kind;
    logic [SLOT_W-1:0]  r_sender_index;
    logic [VALUE_W-1:0] r_sender_value;
    logic [SIZE_W-1:0]  r_sender_size;
    logic [VALUE_W-1:0] r_compare_value;
    logic               r_compare_last;

    // Result register
    logic               r_out_valid;
    logic [KIND_W-1:0]  r_out_kind;
    logic [VALUE_W-1:0] r_out_count;
    logic [REL_W-1:0]   r_out_rel;
    logic               r_out_mismatch;

    // Single-pass datapath signals
    logic                  advance;
    logic                  produces;
    logic [SIZE_W-1:0]     eff_size;
    logic                  owner_ok;
    logic [IW-1:0]         owner_ix;
    logic [IW-1:0]         sender_ix;
    logic [IW-1:0]         pos_ix;
    logic [IW-1:0]         rd_ix;
    logic [COUNT_BITS-1:0] rd_count;
    logic [COUNT_BITS-1:0] bumped;
    logic [COUNT_BITS-1:0] sender_count;
    logic                  do_bump;
    logic                  do_copy;
    logic                  pos_in_range;
    logic                  is_last;
    logic                  mismatch;
    logic [VALUE_W-1:0]    n_count;
    logic [REL_W-1:0]      n_rel;
    logic                  n_smaller;
    logic                  n_larger;
    logic [SIZE_W:0]       pos_plus;

    // Effective size: clock size saturated to storage depth
    assign eff_size = ({27'd0, r_clock_size} > 32'(MAX_ENTRIES)) ? SIZE_W'(MAX_ENTRIES)
                                                                 : r_clock_size;

    assign owner_ok  = {28'd0, r_owner} < 32'(MAX_ENTRIES);
    assign owner_ix  = IW'(r_owner);
    assign sender_ix = IW'(r_sender_index);
    assign pos_ix    = IW'(r_cmp_pos);

    // One counter read per pass: compare position or owner slot
    assign rd_ix    = (r_kind == KIND_CMP) ? pos_ix : owner_ix;
    assign rd_count = r_counters[rd_ix];
    assign bumped   = rd_count + COUNT_BITS'(1);
    assign sender_count = COUNT_BITS'(r_sender_value);

    assign pos_in_range = r_cmp_pos < eff_size;
    assign pos_plus     = {1'b0, r_cmp_pos} + 6'd1;
    assign mismatch     = pos_plus != {1'b0, eff_size};
    assign is_last      = (r_kind == KIND_CMP) && r_compare_last;

    // Decode the item in the input register
    always_comb begin
        do_bump   = 1'b0;
        do_copy   = 1'b0;
        produces  = 1'b0;
        n_count   = '0;
        n_rel     = REL_EQUAL;
        n_smaller = r_seen_smaller;
        n_larger  = r_seen_larger;
        unique case (r_kind)
            KIND_TICK: begin
                produces = 1'b1;
                do_bump  = owner_ok;
                n_count  = owner_ok ? VALUE_W'(bumped) : '0;
            end
            KIND_RECV: begin
                produces = 1'b1;
                do_bump  = owner_ok;
                do_copy  = (r_sender_size == eff_size) && (r_sender_index < eff_size);
                n_count  = owner_ok ? VALUE_W'(bumped) : '0;
                if (do_copy && (r_sender_index == r_owner)) begin
                    n_count = VALUE_W'(sender_count);
                end
            end
            KIND_CMP: begin
                produces = r_compare_last;
                if (pos_in_range) begin
                    if (CW'(rd_count) < CW'(r_compare_value)) begin
                        n_smaller = 1'b1;
                    end else if (CW'(rd_count) > CW'(r_compare_value)) begin
                        n_larger = 1'b1;
                    end
                end
                priority if (mismatch || (n_smaller && n_larger)) begin
                    n_rel = REL_CONC;
                end else if (n_smaller) begin
                    n_rel = REL_BEFORE;
                end else if (n_larger) begin
                    n_rel = REL_AFTER;
                end else begin
                    n_rel = REL_EQUAL;
                end
            end
            default: begin
                produces = 1'b0;
            end
        endcase
    end

    // Move a word on when it gives no result or the result register is free or being emptied
    assign advance    = r_in_valid && (!produces || !r_out_valid || o_out.ready);
    assign i_in.ready = !r_in_valid || advance;
    assign i_cfg.ready = 1'b1;

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_owner      <= '0;
            r_clock_size <= CLOCK_SIZE_RST;
        end else if (i_cfg.valid) begin
            if (i_cfg.index == CFG_OWNER_INDEX) begin
                r_owner <= i_cfg.data[SLOT_W-1:0];
            end else if (i_cfg.index == CFG_CLOCK_SIZE) begin
                r_clock_size <= i_cfg.data;
            end
        end
    end

    // Capture the input word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_in_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.ready && i_in.valid) begin
            r_kind          <= i_in.kind;
            r_sender_index  <= i_in.sender_index;
            r_sender_value  <= i_in.sender_value;
            r_sender_size   <= i_in.sender_size;
            r_compare_value <= i_in.compare_value;
            r_compare_last  <= i_in.compare_last;
        end
    end

    // Update counters: copy the sender value, and bump the owner unless the copy lands on the same slot
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < MAX_ENTRIES; k++) begin
                r_counters[k] <= '0;
            end
        end else if (advance) begin
            if (do_bump && !(do_copy && (sender_ix == owner_ix))) begin
                r_counters[owner_ix] <= bumped;
            end
            if (do_copy) begin
                r_counters[sender_ix] <= sender_count;
            end
        end
    end

    // Advance or clear the compare state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cmp_pos      <= '0;
            r_seen_smaller <= 1'b0;
            r_seen_larger  <= 1'b0;
        end else if (advance && (r_kind == KIND_CMP)) begin
            if (r_compare_last) begin
                r_cmp_pos      <= '0;
                r_seen_smaller <= 1'b0;
                r_seen_larger  <= 1'b0;
            end else begin
                r_seen_smaller <= n_smaller;
                r_seen_larger  <= n_larger;
                if (r_cmp_pos < POS_MAX) begin
                    r_cmp_pos <= pos_plus[SIZE_W-1:0];
                end
            end
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance && produces) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && produces) begin
            r_out_kind     <= r_kind;
            r_out_count    <= n_count;
            r_out_rel      <= (r_kind == KIND_CMP) ? n_rel : REL_EQUAL;
            r_out_mismatch <= (r_kind == KIND_CMP) && mismatch;
        end
    end

    assign o_out.valid         = r_out_valid;
    assign o_out.result_kind   = r_out_kind;
    assign o_out.own_count     = r_out_count;
    assign o_out.relation      = r_out_rel;
    assign o_out.size_mismatch = r_out_mismatch;

    // The last compare element leaves the compare state cleared
    a_cmp_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance && is_last |=> (r_cmp_pos == '0) && !r_seen_smaller && !r_seen_larger)
        else $error("compare state not cleared after last element");

    // A tick always shows up as a tick result in the next cycle
    a_tick_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance && (r_kind == KIND_TICK) |=> r_out_valid && (r_out_kind == KIND_TICK))
        else $error("tick did not produce a tick result");

    // A length mismatch always reads as concurrent
    a_mismatch_conc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out_mismatch |-> (r_out_kind == KIND_CMP) && (r_out_rel == REL_CONC))
        else $error("size mismatch without concurrent relation");

    // Tick and receive results carry no relation
    a_no_rel: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && (r_out_kind != KIND_CMP) |-> (r_out_rel == REL_EQUAL)
            && !r_out_mismatch)
        else $error("relation set on a non-compare result");

endmodule

FILE: tb/sv/vclock_tb_pkg.sv
// Vector clock mirror: word types, a cycle-free copy of the counters and the result checker.
package vclock_tb_pkg;
    timeunit 1ns;
    timeprecision 1ps;

    import vcu_pkg::*;

    // Kind code that the block drops without a result
    localparam logic [KIND_W-1:0] KIND_NONE = 2'd3;
    localparam int SLOTS = 16;

    typedef struct packed {
        logic [KIND_W-1:0]  kind;
        logic [SLOT_W-1:0]  sender_index;
        logic [VALUE_W-1:0] sender_value;
        logic [SIZE_W-1:0]  sender_size;
        logic [VALUE_W-1:0] compare_value;
        logic               compare_last;
    } vclock_word_t;

    typedef struct packed {
        t_kind              kind;
        logic [VALUE_W-1:0] own_count;
        t_rel               relation;
        logic               size_mismatch;
    } vclock_result_t;

    class vclock_mirror;
        logic [VALUE_W-1:0] slot_count [SLOTS];
        logic [SIZE_W-1:0]  cmp_pos;
        logic               seen_lower;
        logic               seen_higher;
        logic [SLOT_W-1:0]  owner;
        logic [SIZE_W-1:0]  clk_size;
        vclock_result_t     pending_results[$];
        int                 errors;

        function new();
            foreach (slot_count[i]) slot_count[i] = '0;
            cmp_pos     = '0;
            seen_lower  = 1'b0;
            seen_higher = 1'b0;
            owner       = '0;
            clk_size    = CLOCK_SIZE_RST;
            errors      = 0;
        endfunction

        // Entries in use: the size register saturated to the storage depth
        function logic [SIZE_W-1:0] live_size();
            return (clk_size > SLOTS) ? SIZE_W'(SLOTS) : clk_size;
        endfunction

        function int pending();
            return pending_results.size();
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_OWNER_INDEX: owner = data[SLOT_W-1:0];
                CFG_CLOCK_SIZE:  clk_size = data;
                default: ;
            endcase
        endfunction

        // Advance the mirror by one accepted word and queue the result it causes
        function void apply_word(vclock_word_t w);
            vclock_result_t r;
            logic [SIZE_W-1:0] lim;
            logic mism;
            lim = live_size();
            r = '0;
            case (w.kind)
                KIND_TICK: begin
                    slot_count[owner] = slot_count[owner] + 1'b1;
                    r.kind      = KIND_TICK;
                    r.own_count = slot_count[owner];
                    pending_results.push_back(r);
                end
                KIND_RECV: begin
                    slot_count[owner] = slot_count[owner] + 1'b1;
                    // copy only when the sizes agree and the sender lies inside the clock
                    if (w.sender_size == lim && {1'b0, w.sender_index} < lim)
                        slot_count[w.sender_index] = w.sender_value;
                    r.kind      = KIND_RECV;
                    r.own_count = slot_count[owner];
                    pending_results.push_back(r);
                end
                KIND_CMP: begin
                    if (cmp_pos < lim) begin
                        if (slot_count[cmp_pos[SLOT_W-1:0]] < w.compare_value)
                            seen_lower = 1'b1;
                        else if (slot_count[cmp_pos[SLOT_W-1:0]] > w.compare_value)
                            seen_higher = 1'b1;
                    end
                    if (!w.compare_last) begin
                        if (cmp_pos != POS_MAX)
                            cmp_pos = cmp_pos + 1'b1;
                    end else begin
                        mism = ({1'b0, cmp_pos} + 6'd1) != {1'b0, lim};
                        r.kind          = KIND_CMP;
                        r.size_mismatch = mism;
                        if (mism || (seen_lower && seen_higher))
                            r.relation = REL_CONC;
                        else if (seen_lower)
                            r.relation = REL_BEFORE;
                        else if (seen_higher)
                            r.relation = REL_AFTER;
                        else
                            r.relation = REL_EQUAL;
                        pending_results.push_back(r);
                        cmp_pos     = '0;
                        seen_lower  = 1'b0;
                        seen_higher = 1'b0;
                    end
                end
                default: ;
            endcase
        endfunction

        function void check_field(string name, logic [VALUE_W-1:0] exp_v,
                                  logic [VALUE_W-1:0] got_v);
            if (got_v !== exp_v) begin
                $display("%0t: %s mismatch, expected %h, got %h", $time, name, exp_v, got_v);
                errors++;
            end
        endfunction

        // Check one result word against the oldest expectation
        function void check_word(vclock_result_t got);
            vclock_result_t want;
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result, expected none, got kind %0d count %h",
                         $time, got.kind, got.own_count);
                errors++;
                return;
            end
            want = pending_results.pop_front();
            check_field("result_kind", VALUE_W'(want.kind), VALUE_W'(got.kind));
            check_field("own_count", want.own_count, got.own_count);
            check_field("relation", VALUE_W'(want.relation), VALUE_W'(got.relation));
            check_field("size_mismatch", VALUE_W'(want.size_mismatch),
                        VALUE_W'(got.size_mismatch));
        endfunction
    endclass

endpackage

FILE: tb/sv/tb_vector_clock_unit.sv
// Testbench top for the vector clock unit: stimulus tasks, monitors and run control.
module tb_vector_clock_unit;
    timeunit 1ns;
    timeprecision 1ps;

    import vcu_pkg::*;
    import vclock_tb_pkg::*;

    localparam int CYCLE_LIMIT = 300000;
    localparam int PHASE_WORDS = 88;
    localparam int PHASES      = 8;

    logic i_clk;
    logic i_rst_n;

    vcu_in_if  in_if();
    vcu_out_if out_if();
    vcu_cfg_if cfg_if();

    vector_clock_unit u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if),
        .i_cfg   (cfg_if)
    );

    vclock_mirror mirror;
    int src_idle_pct;
    int sink_stall_pct;
    int cmp_left;
    int cmp_style;
    int cycles;

    // Clock starts high so no falling edge lands at time zero
    initial begin
        i_clk = 1'b1;
        forever #6 i_clk = ~i_clk;
    end

    // Watchdog
    initial cycles = 0;
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // Receiver stalls at random
    always @(negedge i_clk) begin
        out_if.ready <= ($urandom_range(0, 99) >= sink_stall_pct);
    end

    // Monitor the three channels
    always @(posedge i_clk) begin : monitor
        vclock_word_t   w;
        vclock_result_t r;
        if (i_rst_n === 1'b1) begin
            if (cfg_if.valid && cfg_if.ready)
                mirror.write_reg(cfg_if.index, cfg_if.data);
            if (in_if.valid && in_if.ready) begin
                w.kind          = in_if.kind;
                w.sender_index  = in_if.sender_index;
                w.sender_value  = in_if.sender_value;
                w.sender_size   = in_if.sender_size;
                w.compare_value = in_if.compare_value;
                w.compare_last  = in_if.compare_last;
                mirror.apply_word(w);
            end
            if (out_if.valid && out_if.ready) begin
                r.kind          = t_kind'(out_if.result_kind);
                r.own_count     = out_if.own_count;
                r.relation      = t_rel'(out_if.relation);
                r.size_mismatch = out_if.size_mismatch;
                mirror.check_word(r);
            end
        end
    end

    // Random filler for the fields a kind does not use
    function automatic vclock_word_t noise_word();
        vclock_word_t w;
        w.kind          = KIND_NONE;
        w.sender_index  = SLOT_W'($urandom());
        w.sender_value  = $urandom();
        w.sender_size   = SIZE_W'($urandom());
        w.compare_value = $urandom();
        w.compare_last  = 1'($urandom());
        return w;
    endfunction

    // Offer one word, idling first at random; returns on the falling edge after the handshake
    task automatic send_word(input vclock_word_t w);
        while ($urandom_range(0, 99) < src_idle_pct) begin
            in_if.valid <= 1'b0;
            @(negedge i_clk);
        end
        in_if.valid         <= 1'b1;
        in_if.kind          <= w.kind;
        in_if.sender_index  <= w.sender_index;
        in_if.sender_value  <= w.sender_value;
        in_if.sender_size   <= w.sender_size;
        in_if.compare_value <= w.compare_value;
        in_if.compare_last  <= w.compare_last;
        do @(posedge i_clk); while (in_if.ready !== 1'b1);
        @(negedge i_clk);
    endtask

    task automatic send_tick();
        vclock_word_t w;
        w = noise_word();
        w.kind = KIND_TICK;
        send_word(w);
    endtask

    task automatic send_recv(input logic [SLOT_W-1:0] idx, input logic [VALUE_W-1:0] val,
                             input logic [SIZE_W-1:0] size);
        vclock_word_t w;
        w = noise_word();
        w.kind         = KIND_RECV;
        w.sender_index = idx;
        w.sender_value = val;
        w.sender_size  = size;
        send_word(w);
    endtask

    task automatic send_cmp(input logic [VALUE_W-1:0] val, input logic last);
        vclock_word_t w;
        w = noise_word();
        w.kind          = KIND_CMP;
        w.compare_value = val;
        w.compare_last  = last;
        send_word(w);
    endtask

    // Drop valid and hold until every expected result is in and the pipe is empty
    task automatic wait_settled();
        in_if.valid <= 1'b0;
        while (mirror.pending() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic write_config(input logic [SLOT_W-1:0] owner, input logic [SIZE_W-1:0] size);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= CFG_OWNER_INDEX;
        cfg_if.data  <= {1'b0, owner};
        do @(posedge i_clk); while (cfg_if.ready !== 1'b1);
        @(negedge i_clk);
        cfg_if.index <= CFG_CLOCK_SIZE;
        cfg_if.data  <= size;
        do @(posedge i_clk); while (cfg_if.ready !== 1'b1);
        @(negedge i_clk);
        cfg_if.valid <= 1'b0;
    endtask

    // Pick the length and flavor of a new compared clock
    task automatic start_compare();
        int lim;
        int pick;
        lim = mirror.live_size();
        pick = $urandom_range(0, 9);
        cmp_style = $urandom_range(0, 3);
        if (pick < 7)
            cmp_left = (lim == 0) ? 1 : lim;
        else if (pick == 7)
            cmp_left = lim + 1;
        else if (pick == 8)
            cmp_left = (lim > 1) ? lim - 1 : 1;
        else
            cmp_left = $urandom_range(1, 40);
    endtask

    // Next element, mostly near the local counter so all relations show up
    task automatic send_cmp_element();
        logic [VALUE_W-1:0] mine;
        logic [VALUE_W-1:0] val;
        int p;
        p = mirror.cmp_pos;
        mine = (p < SLOTS) ? mirror.slot_count[p] : $urandom();
        case (cmp_style)
            0: val = mine;
            1: val = ($urandom_range(0, 3) == 0) ? mine + $urandom_range(1, 3) : mine;
            2: val = ($urandom_range(0, 3) == 0) ? mine - $urandom_range(1, 3) : mine;
            default: begin
                case ($urandom_range(0, 3))
                    0: val = mine;
                    1: val = mine + 1'b1;
                    2: val = mine - 1'b1;
                    default: val = $urandom();
                endcase
            end
        endcase
        send_cmp(val, cmp_left == 1);
        cmp_left--;
    endtask

    task automatic random_word();
        int pick;
        logic [VALUE_W-1:0] val;
        logic [SIZE_W-1:0] size;
        pick = $urandom_range(0, 99);
        val  = ($urandom_range(0, 6) == 0) ? 32'hFFFF_FFFF - $urandom_range(0, 2) : $urandom();
        size = ($urandom_range(0, 3) != 0) ? mirror.live_size() : SIZE_W'($urandom_range(0, 31));
        if (cmp_left > 0) begin
            // mostly continue the compare, sometimes slip a tick or receive in
            if (pick < 75)
                send_cmp_element();
            else if (pick < 85)
                send_tick();
            else if (pick < 95)
                send_recv(SLOT_W'($urandom()), val, size);
            else
                send_word(noise_word());
        end else begin
            if (pick < 30)
                send_tick();
            else if (pick < 60)
                send_recv(SLOT_W'($urandom()), val, size);
            else if (pick < 95) begin
                start_compare();
                send_cmp_element();
            end else
                send_word(noise_word());
        end
        if ($urandom_range(0, 199) == 0)
            wait_settled();
    endtask

    initial begin : stimulus
        int owner_set [PHASES];
        int size_set [PHASES];
        int idle_set [4];
        int stall_set [4];
        int ph;
        int n;
        owner_set = '{0, 15, 5, 10, 3, 12, 7, 0};
        size_set  = '{16, 1, 8, 16, 31, 2, 0, 15};
        idle_set  = '{0, 52, 0, 17};
        stall_set = '{0, 0, 52, 17};
        mirror = new();
        src_idle_pct   = 0;
        sink_stall_pct = 0;
        cmp_left  = 0;
        cmp_style = 0;
        i_rst_n <= 1'b0;
        in_if.valid         <= 1'b0;
        in_if.kind          <= '0;
        in_if.sender_index  <= '0;
        in_if.sender_value  <= '0;
        in_if.sender_size   <= '0;
        in_if.compare_value <= '0;
        in_if.compare_last  <= 1'b0;
        cfg_if.valid <= 1'b0;
        cfg_if.index <= CFG_OWNER_INDEX;
        cfg_if.data  <= '0;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed: owner 0, full clock after reset
        send_tick();
        send_recv(4'd0, 32'hFFFF_FFFF, 5'd16);   // sender is the owner
        send_tick();                              // counter wraps
        send_recv(4'd15, 32'h5555_5555, 5'd16);
        send_recv(4'd2, 32'h1234_5678, 5'd4);     // size mismatch, increment only
        send_recv(4'd15, 32'h0, 5'd31);
        send_word(noise_word());                  // dropped kind
        wait_settled();

        // Directed: one-entry clock, owner outside it
        write_config(4'd15, 5'd1);
        send_tick();
        send_recv(4'd0, 32'hAAAA_AAAA, 5'd1);
        send_recv(4'd1, 32'h0, 5'd1);             // sender outside the clock
        send_cmp(mirror.slot_count[0], 1'b1);
        send_cmp(mirror.slot_count[0] + 1'b1, 1'b1);
        send_cmp(mirror.slot_count[0] - 1'b1, 1'b1);
        send_cmp(mirror.slot_count[0], 1'b0);     // two elements: length mismatch
        send_cmp(32'h0, 1'b1);
        wait_settled();

        // Directed: tick in the middle of a compare, concurrent outcome
        write_config(4'd0, 5'd2);
        send_cmp(32'h0, 1'b0);
        send_tick();
        send_cmp(32'hFFFF_FFFF, 1'b1);

        // Random phases over configurations and idle patterns
        for (ph = 0; ph < PHASES; ph++) begin
            wait_settled();
            write_config(SLOT_W'(owner_set[ph]), SIZE_W'(size_set[ph]));
            src_idle_pct   = idle_set[ph % 4];
            sink_stall_pct = stall_set[ph % 4];
            for (n = 0; n < PHASE_WORDS || cmp_left > 0; n++)
                random_word();
        end

        in_if.valid <= 1'b0;
        while (mirror.pending() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (mirror.errors == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
